### rtl/i2c_master_transaction_sequencer_macros.svh
// assertion macros used by the port-level checker
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define SEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication, ignored while reset is held
`define SEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

### rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types, status codes and command codes of the i2c transaction sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

    // default size of the transmit / receive byte buffer
    localparam int BUF_DEPTH_DEF = 16;
    // depth of the queues between front, back and result port
    localparam int QUEUE_DEPTH   = 2;

    // item modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // engine status codes, upper five bits of the status byte
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_WR_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_WR_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_WR_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_RD_ADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RD_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RD_DATA_NACK = 8'h58;
    // r/w bit appended to the address byte
    localparam logic       RW_WRITE        = 1'b0;
    localparam logic       RW_READ         = 1'b1;

    // engine commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    // input item
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic       want_write;
        logic       want_read;
        logic [4:0] write_count;
        logic [4:0] read_count;
        logic       has_handler;
        logic [7:0] bus_status;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       failed;
        logic       busy_res;
    } t_res_item;

    // item class decided by the front
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_START,
        OP_EVENT,
        OP_CLEAR
    } t_op;

    // bus event class decided by the front
    typedef enum logic [2:0] {
        EV_ADDR,
        EV_MT_ACK,
        EV_MT_NACK,
        EV_MR_SLA,
        EV_MR_ACK,
        EV_MR_NACK,
        EV_UNKNOWN
    } t_ev;

    // classified item queued between front and back
    typedef struct packed {
        t_op        op;
        t_ev        ev;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic       want_write;
        logic       want_read;
        logic [4:0] send_count;
        logic [4:0] recv_count;
        logic       has_handler;
    } t_q_item;

    // transaction phase flags
    typedef struct packed {
        logic write;
        logic read;
        logic busy;
        logic error;
    } t_flags;

endpackage

### rtl/i2cseq_fifo.sv
// ----------------------------------------------------------------------------
// i2cseq_fifo
// Small register queue with push / full and pop / empty sides.
// ----------------------------------------------------------------------------
module i2cseq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wptr, r_rptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTRW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTRW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/i2cseq_front.sv
// ----------------------------------------------------------------------------
// i2cseq_front
// Accepts items, classifies mode and bus status, clamps counts and queues
// the classified item for the back end.
// ----------------------------------------------------------------------------
module i2cseq_front #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  i2cseq_pkg::t_in_item  i_item,
    output logic                  o_full,
    input  logic                  i_q_pop,
    output i2cseq_pkg::t_q_item   o_q_item,
    output logic                  o_q_valid
);
    import i2cseq_pkg::*;

    localparam int         CLAMP   = (BUF_DEPTH < 31) ? BUF_DEPTH : 31;
    localparam int         IDX_LIM = (BUF_DEPTH < 16) ? BUF_DEPTH : 16;
    localparam logic [4:0] CLAMP_V = 5'(CLAMP);
    localparam logic [4:0] IDX_V   = 5'(IDX_LIM);

    t_q_item    cls;
    logic [7:0] code;
    logic       q_empty;

    assign code = {i_item.bus_status[7:3], 3'b000};

    // classify the incoming item
    always_comb begin
        cls.index          = i_item.index;
        cls.data_byte      = i_item.data_byte;
        cls.device_address = i_item.device_address;
        cls.want_write     = i_item.want_write;
        cls.want_read      = i_item.want_read;
        cls.has_handler    = i_item.has_handler;
        cls.send_count     = (i_item.write_count > CLAMP_V) ? CLAMP_V : i_item.write_count;
        cls.recv_count     = (i_item.read_count > CLAMP_V) ? CLAMP_V : i_item.read_count;

        case (i_item.mode)
            MODE_LOAD:   cls.op = ({1'b0, i_item.index} < IDX_V) ? OP_LOAD : OP_IDLE;
            MODE_START:  cls.op = OP_START;
            MODE_STATUS: cls.op = OP_EVENT;
            MODE_CLEAR:  cls.op = OP_CLEAR;
            default:     cls.op = OP_IDLE;
        endcase

        case (code)
            ST_START, ST_REP_START:         cls.ev = EV_ADDR;
            ST_WR_ADDR_ACK, ST_WR_DATA_ACK: cls.ev = EV_MT_ACK;
            ST_WR_DATA_NACK:                cls.ev = EV_MT_NACK;
            ST_RD_ADDR_ACK:                 cls.ev = EV_MR_SLA;
            ST_RD_DATA_ACK:                 cls.ev = EV_MR_ACK;
            ST_RD_DATA_NACK:                cls.ev = EV_MR_NACK;
            default:                        cls.ev = EV_UNKNOWN;
        endcase
    end

    // queue towards the back end
    i2cseq_fifo #(
        .WIDTH ($bits(t_q_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_q_pop),
        .o_data  (o_q_item),
        .o_empty (q_empty)
    );

    assign o_q_valid = !q_empty;

endmodule

### rtl/i2cseq_back.sv
// ----------------------------------------------------------------------------
// i2cseq_back
// Carries out one classified item a cycle while the result queue has room:
// transaction state, byte buffer, engine command, and a result queue to the port.
// ----------------------------------------------------------------------------
module i2cseq_back #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cseq_pkg::t_q_item   i_q_item,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output i2cseq_pkg::t_res_item o_res,
    output logic                  o_empty
);
    import i2cseq_pkg::*;

    localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW    = $clog2(BUF_DEPTH + 1);
    localparam int CMPW  = (PW > 5) ? PW : 5;
    localparam int CMPW1 = CMPW + 1;

    // transaction state
    logic [6:0]    r_addr, n_addr;
    t_flags        r_flags, n_flags;
    logic [4:0]    r_send, n_send;
    logic [4:0]    r_recv, n_recv;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_handler, n_handler;

    // byte buffer with a registered read at the next position
    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    logic          step, res_full;
    logic          wr_end, rx_store, rx_next;
    logic [CMPW-1:0] pos_ext;
    t_res_item     res;

    assign step    = i_q_valid && !res_full;
    assign o_q_pop = step;
    assign pos_ext = CMPW'(r_pos);
    assign mem_ra  = AW'(n_pos);

    // execute one item
    always_comb begin
        n_addr    = r_addr;
        n_flags   = r_flags;
        n_send    = r_send;
        n_recv    = r_recv;
        n_pos     = r_pos;
        n_handler = r_handler;
        mem_we    = 1'b0;
        mem_wa    = AW'(i_q_item.index);
        mem_wd    = i_q_item.data_byte;
        wr_end    = 1'b0;
        rx_store  = 1'b0;
        rx_next   = 1'b0;
        res       = '0;

        if (step) begin
            case (i_q_item.op)
                OP_LOAD: begin
                    mem_we = 1'b1;
                end
                OP_START: begin
                    if (!r_flags.error) begin
                        n_addr        = i_q_item.device_address;
                        n_flags.write = i_q_item.want_write;
                        n_flags.read  = i_q_item.want_read;
                        n_flags.busy  = 1'b1;
                        n_flags.error = 1'b0;
                        n_send        = i_q_item.send_count;
                        n_recv        = i_q_item.recv_count;
                        n_handler     = i_q_item.has_handler;
                        res.command   = CMD_START;
                    end
                end
                OP_EVENT: begin
                    if (r_flags.busy) begin
                        case (i_q_item.ev)
                            EV_ADDR: begin
                                n_pos       = '0;
                                res.command = CMD_SEND;
                                res.tx_byte = {r_addr, r_flags.write ? RW_WRITE : RW_READ};
                            end
                            EV_MT_ACK: begin
                                if (pos_ext < CMPW'(r_send) && pos_ext < CMPW'(BUF_DEPTH)) begin
                                    res.command = CMD_SEND;
                                    res.tx_byte = r_rd_data;
                                    n_pos       = r_pos + 1'b1;
                                end else begin
                                    wr_end = 1'b1;
                                end
                            end
                            EV_MT_NACK: begin
                                wr_end = 1'b1;
                            end
                            EV_MR_ACK: begin
                                rx_store = 1'b1;
                                rx_next  = 1'b1;
                            end
                            EV_MR_SLA: begin
                                rx_next = 1'b1;
                            end
                            EV_MR_NACK: begin
                                rx_store     = 1'b1;
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                                n_flags.read = 1'b0;
                                if (!r_handler) begin
                                    n_flags.busy = 1'b0;
                                end
                            end
                            default: begin
                                n_flags.error = 1'b1;
                                res.command   = CMD_STOP;
                                res.done_res  = 1'b1;
                            end
                        endcase

                        // end of the write phase: repeated start or stop
                        if (wr_end) begin
                            n_flags.write = 1'b0;
                            if (n_flags.read) begin
                                res.command = CMD_START;
                            end else begin
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                                if (!r_handler) begin
                                    n_flags.busy = 1'b0;
                                end
                            end
                        end

                        // store a received byte while there is room
                        if (rx_store && pos_ext < CMPW'(BUF_DEPTH)) begin
                            mem_we       = 1'b1;
                            mem_wa       = AW'(r_pos);
                            res.rx_valid = 1'b1;
                            res.rx_index = 4'(r_pos);
                            res.rx_byte  = i_q_item.data_byte;
                            n_pos        = r_pos + 1'b1;
                        end

                        // ack all but the last byte to receive
                        if (rx_next) begin
                            res.command = (CMPW1'(n_pos) + CMPW1'(1) < CMPW1'(r_recv))
                                        ? CMD_RX_ACK : CMD_RX_NACK;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_flags   = '0;
                    n_addr    = '0;
                    n_handler = 1'b0;
                end
                default: begin
                end
            endcase
        end

        res.failed   = n_flags.error;
        res.busy_res = n_flags.busy;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_flags   <= '0;
            r_send    <= '0;
            r_recv    <= '0;
            r_pos     <= '0;
            r_handler <= 1'b0;
        end else begin
            r_addr    <= n_addr;
            r_flags   <= n_flags;
            r_send    <= n_send;
            r_recv    <= n_recv;
            r_pos     <= n_pos;
            r_handler <= n_handler;
        end
    end

    // byte buffer, read data follows the position with write forwarding
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= (mem_we && mem_wa == mem_ra) ? mem_wd : r_mem[mem_ra];
    end

    // result queue
    i2cseq_fifo #(
        .WIDTH ($bits(t_res_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

### rtl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Write-then-read i2c master sequencer above a byte-level bus engine.
//
//   channel   direction  handshake          payload
//   request   in         push / full        i_item   (t_in_item)
//   result    out        empty / pop        o_result (t_res_item)
//
// One item a cycle sustained while the result queue has room; an accepted
// item is registered in the front queue, the back end steps on it from there
// and its result is registered in the result queue.
// The back end step and its buffer read port set the rate of one item a cycle.
// Synchronous reset clears both queues and the transaction state; the byte
// buffer is not cleared. A full result queue stalls the back end; a full
// front queue raises full.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  i2cseq_pkg::t_in_item  i_item,
    output logic                  empty,
    input  logic                  pop,
    output i2cseq_pkg::t_res_item o_result
);
    import i2cseq_pkg::*;

    t_q_item q_item;
    logic    q_valid, q_pop;

    // accept and classify
    i2cseq_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item),
        .o_q_valid (q_valid)
    );

    // execute and queue results
    i2cseq_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_item),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_res     (o_result),
        .o_empty   (empty)
    );

endmodule

### rtl/i2cseq_checker.sv
// ----------------------------------------------------------------------------
// i2cseq_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_macros.svh"

module i2cseq_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  empty,
    input logic                  pop,
    input i2cseq_pkg::t_res_item i_result
);
    import i2cseq_pkg::*;

    logic res_done, res_rx, res_tx;
    logic cmd_stop, cmd_rx_ok, cmd_send;

    // terms of the checks on the waiting result
    assign res_done  = !empty && i_result.done_res;
    assign res_rx    = !empty && i_result.rx_valid;
    assign res_tx    = !empty && (i_result.tx_byte != 8'h00);
    assign cmd_stop  = (i_result.command == CMD_STOP);
    assign cmd_rx_ok = (i_result.command inside {CMD_RX_ACK, CMD_RX_NACK, CMD_STOP});
    assign cmd_send  = (i_result.command == CMD_SEND);

    // a waiting result holds until taken
    `SEQ_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, $stable(i_result))

    // a finished transaction always ends with a stop
    `SEQ_ASSERT_NOW(a_done_stop, i_clk, i_rst_n, res_done, cmd_stop)

    // a received byte comes with a receive or a stop command
    `SEQ_ASSERT_NOW(a_rx_cmd, i_clk, i_rst_n, res_rx, cmd_rx_ok)

    // a byte to send only comes with a send command
    `SEQ_ASSERT_NOW(a_tx_send, i_clk, i_rst_n, res_tx, cmd_send)

endmodule

bind i2c_master_transaction_sequencer i2cseq_checker u_i2cseq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .i_result (o_result)
);

### dv/sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequencer_checker
// Watches the item and result queues of the i2c transaction sequencer. It
// keeps its own copy of the transaction state and the byte buffer, works out
// the engine command for every accepted item, and compares each popped
// result with the oldest outstanding command.
// ----------------------------------------------------------------------------
module sequencer_checker #(
    parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  i2cseq_pkg::t_in_item  i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  i2cseq_pkg::t_res_item i_result,
    output int                    o_fail_count,
    output int                    o_pending
);
    import i2cseq_pkg::*;

    // mirrored transaction state
    logic [7:0]  byte_buf [BUF_DEPTH];
    logic [6:0]  target_addr;
    t_flags      flags;
    int unsigned send_total;
    int unsigned recv_total;
    int unsigned buf_pos;
    logic        handler_on;

    // commands still to come out, oldest first
    t_res_item   pending_cmds [$];

    function automatic int unsigned sat_count(input logic [4:0] c);
        return (c > BUF_DEPTH) ? BUF_DEPTH : c;
    endfunction

    // one step of the sequencer: update state, return the result item
    function automatic t_res_item next_command(input t_in_item it);
        t_res_item r;
        logic [7:0] code;
        logic store_rx;
        logic ask_rx;
        logic write_over;
        r = '0;
        store_rx = 1'b0;
        ask_rx = 1'b0;
        write_over = 1'b0;
        case (it.mode)
            MODE_LOAD: begin
                if (it.index < BUF_DEPTH) byte_buf[it.index] = it.data_byte;
            end
            MODE_START: begin
                if (!flags.error) begin
                    target_addr = it.device_address;
                    flags = '0;
                    flags.busy = 1'b1;
                    flags.write = it.want_write;
                    flags.read = it.want_read;
                    send_total = sat_count(it.write_count);
                    recv_total = sat_count(it.read_count);
                    handler_on = it.has_handler;
                    r.command = CMD_START;
                end
            end
            MODE_STATUS: begin
                if (flags.busy) begin
                    code = it.bus_status & 8'hF8;
                    case (code)
                        ST_START, ST_REP_START: begin
                            buf_pos = 0;
                            r.command = CMD_SEND;
                            r.tx_byte = {target_addr, flags.write ? RW_WRITE : RW_READ};
                        end
                        ST_WR_ADDR_ACK, ST_WR_DATA_ACK: begin
                            if (buf_pos < send_total && buf_pos < BUF_DEPTH) begin
                                r.command = CMD_SEND;
                                r.tx_byte = byte_buf[buf_pos];
                                buf_pos++;
                            end else begin
                                write_over = 1'b1;
                            end
                        end
                        ST_WR_DATA_NACK: write_over = 1'b1;
                        ST_RD_DATA_ACK: begin
                            store_rx = 1'b1;
                            ask_rx = 1'b1;
                        end
                        ST_RD_ADDR_ACK: ask_rx = 1'b1;
                        ST_RD_DATA_NACK: begin
                            store_rx = 1'b1;
                            r.command = CMD_STOP;
                            flags.read = 1'b0;
                            r.done_res = 1'b1;
                            if (!handler_on) flags.busy = 1'b0;
                        end
                        default: begin
                            // unknown status: sticky error, busy stays set
                            flags.error = 1'b1;
                            r.command = CMD_STOP;
                            r.done_res = 1'b1;
                        end
                    endcase
                    // end of write phase: repeated start or stop
                    if (write_over) begin
                        flags.write = 1'b0;
                        if (flags.read) begin
                            r.command = CMD_START;
                        end else begin
                            r.command = CMD_STOP;
                            r.done_res = 1'b1;
                            if (!handler_on) flags.busy = 1'b0;
                        end
                    end
                    // received byte, dropped once the buffer is full
                    if (store_rx && buf_pos < BUF_DEPTH) begin
                        byte_buf[buf_pos] = it.data_byte;
                        r.rx_valid = 1'b1;
                        r.rx_index = buf_pos[3:0];
                        r.rx_byte = it.data_byte;
                        buf_pos++;
                    end
                    // nack on the last byte to receive
                    if (ask_rx) r.command = (buf_pos + 1 < recv_total) ? CMD_RX_ACK : CMD_RX_NACK;
                end
            end
            default: begin
                flags = '0;
                target_addr = '0;
                handler_on = 1'b0;
            end
        endcase
        r.failed = flags.error;
        r.busy_res = flags.busy;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got, want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_result(input t_res_item got, want);
        if (got.command !== want.command)
            report_mismatch("command", 8'(got.command), 8'(want.command));
        if (got.tx_byte !== want.tx_byte) report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
        if (got.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
        if (got.rx_index !== want.rx_index)
            report_mismatch("rx_index", 8'(got.rx_index), 8'(want.rx_index));
        if (got.rx_byte !== want.rx_byte) report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
        if (got.failed !== want.failed)
            report_mismatch("failed", 8'(got.failed), 8'(want.failed));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
    endtask

    // compare popped results, then predict for the accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            target_addr = '0;
            flags = '0;
            send_total = 0;
            recv_total = 0;
            buf_pos = 0;
            handler_on = 1'b0;
            pending_cmds.delete();
            o_fail_count = 0;
            o_pending <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_cmds.size() == 0)
                    report_mismatch("result with no item waiting",
                                    8'(i_result.command), 8'h00);
                else
                    check_result(i_result, pending_cmds.pop_front());
            end
            if (i_push && !i_full) pending_cmds.push_back(next_command(i_item));
            o_pending <= pending_cmds.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the i2c transaction sequencer with a short directed set of
// transactions and then with randomised well-formed write / read transactions
// mixed with stray events, clears and restarts. Both queue sides idle at
// random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cseq_pkg::*;

    localparam int RANDOM_ITEMS = 600;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_res_item result;
    int        fail_count;
    int        pending;

    // no idling on either side while set
    logic        calm = 1'b0;
    // set by a stray item, cleared when a clear item is sent
    logic        upset = 1'b0;
    // buffer entries that have been loaded at least once
    logic [15:0] loaded = '0;
    int          n_sent = 0;
    int          n_directed;
    logic        mid_drain_done = 1'b0;

    i2c_master_transaction_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    sequencer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 22);
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic t_in_item random_fill();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // hand one item over, with a random gap in front of it
    task automatic send_item(input t_in_item it);
        if (!calm) begin
            while ($urandom_range(99) < 22) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_status(input logic [7:0] code);
        t_in_item it;
        it = random_fill();
        it.mode = MODE_STATUS;
        it.bus_status = code | 8'($urandom_range(7));
        send_item(it);
    endtask

    task automatic send_load(input logic [3:0] idx, input logic [7:0] data);
        t_in_item it;
        it = random_fill();
        it.mode = MODE_LOAD;
        it.index = idx;
        it.data_byte = data;
        loaded[idx] = 1'b1;
        send_item(it);
    endtask

    task automatic send_clear();
        t_in_item it;
        it = random_fill();
        it.mode = MODE_CLEAR;
        upset = 1'b0;
        send_item(it);
    endtask

    // every byte that the write phase may send is loaded before the start
    task automatic issue_start(input logic [6:0] addr, input logic ww, wr,
                               input int wc, rc, input logic hh);
        t_in_item it;
        int i;
        for (i = 0; i < ((wc > 16) ? 16 : wc); i++)
            if (!loaded[i]) send_load(i[3:0], 8'($urandom));
        it = random_fill();
        it.mode = MODE_START;
        it.device_address = addr;
        it.want_write = ww;
        it.want_read = wr;
        it.write_count = wc[4:0];
        it.read_count = rc[4:0];
        it.has_handler = hh;
        send_item(it);
    endtask

    // let every outstanding result come out before going on
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(4);
        if (r < 92) return $urandom_range(16, 5);
        return $urandom_range(31, 17);
    endfunction

    // occasional stray item in the middle of a transaction
    task automatic maybe_stray();
        if ($urandom_range(99) < 4) begin
            upset = 1'b1;
            case ($urandom_range(4))
                0: send_status(8'($urandom));
                1: send_clear();
                2: issue_start(7'($urandom), 1'($urandom), 1'($urandom),
                               $urandom_range(4), $urandom_range(31), 1'($urandom));
                3: send_load(4'($urandom), 8'($urandom));
                default: send_status(ST_RD_DATA_ACK);
            endcase
        end
    endtask

    // well-formed transaction with random content
    task automatic run_transaction();
        logic ww, wr, hh;
        int wc, rc, nw, nr, i;
        logic nacked;
        ww = 1'($urandom);
        wr = 1'($urandom);
        hh = 1'($urandom);
        wc = pick_count();
        rc = pick_count();
        nw = (wc > 16) ? 16 : wc;
        nr = (rc > 16) ? 16 : rc;
        nacked = 1'b0;
        issue_start(7'($urandom), ww, wr, wc, rc, hh);
        send_status(ST_START);
        maybe_stray();
        if (ww) begin
            send_status(ST_WR_ADDR_ACK);
            for (i = 0; i < nw && !nacked; i++) begin
                maybe_stray();
                if ($urandom_range(99) < 3) begin
                    // target refuses a byte: write phase ends early
                    send_status(ST_WR_DATA_NACK);
                    nacked = 1'b1;
                end else begin
                    send_status(ST_WR_DATA_ACK);
                end
            end
            if (wr) send_status(ST_REP_START);
        end
        if (wr || !ww) begin
            send_status(ST_RD_ADDR_ACK);
            for (i = 1; i < nr; i++) begin
                maybe_stray();
                send_status(ST_RD_DATA_ACK);
            end
            // overrun past the end of the buffer
            if (nr == 16 && $urandom_range(1)) begin
                send_status(ST_RD_DATA_ACK);
                send_status(ST_RD_DATA_ACK);
            end
            send_status(ST_RD_DATA_NACK);
        end
        if (upset || $urandom_range(2) == 0) send_clear();
    endtask

    task automatic directed_checks();
        // event and clear with nothing in progress
        send_status(ST_START);
        send_clear();
        // full write then read, with a load while busy
        issue_start(7'h7F, 1'b1, 1'b1, 2, 2, 1'b0);
        send_status(ST_START);
        send_status(ST_WR_ADDR_ACK);
        send_load(4'd15, 8'hFF);
        send_status(ST_WR_DATA_ACK);
        send_status(ST_WR_DATA_ACK);
        send_status(ST_REP_START);
        send_status(ST_RD_ADDR_ACK);
        send_status(ST_RD_DATA_ACK);
        send_status(ST_RD_DATA_NACK);
        // no phase requested, nothing to read
        issue_start(7'h00, 1'b0, 1'b0, 0, 0, 1'b0);
        send_status(ST_START);
        send_status(ST_RD_ADDR_ACK);
        send_status(ST_RD_DATA_NACK);
        // saturated read count, handler, then an unknown status code
        issue_start(7'h55, 1'b1, 1'b1, 0, 31, 1'b1);
        send_status(ST_START);
        send_status(ST_WR_ADDR_ACK);
        send_status(ST_REP_START);
        send_status(ST_RD_ADDR_ACK);
        send_status(8'h00);
        // start refused while the error is set
        issue_start(7'h2A, 1'b1, 1'b0, 1, 0, 1'b0);
        send_clear();
        // data nack cuts the write short
        issue_start(7'h2A, 1'b1, 1'b0, 2, 0, 1'b0);
        send_status(ST_START);
        send_status(ST_WR_ADDR_ACK);
        send_status(ST_WR_DATA_NACK);
    endtask

    // stimulus and verdict
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_checks();
        drain_results();
        n_directed = n_sent;
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            calm <= (n_sent >= n_directed + 250) && (n_sent < n_directed + 400);
            run_transaction();
            if (!mid_drain_done && n_sent >= n_directed + 450) begin
                drain_results();
                mid_drain_done = 1'b1;
            end
        end
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
